// File: hdl/bcis_pkg.sv
// Shared types, codes and defaults for the binned CDF index sampler.
`default_nettype none
package bcis_pkg;

	localparam int BCIS_LEVELS  = 8;
	localparam int BCIS_ENTRIES = 64;

	// Function codes of a request word.
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic [15:0] SAMPLE_TOP = 16'hFFFF;

	typedef struct packed {
		logic        func;
		logic [2:0]  level;
		logic [5:0]  entry;
		logic [2:0]  entry_bin;
		logic [15:0] entry_cdf;
		logic [2:0]  element;
		logic [15:0] random_value;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [5:0] chosen_entry;
	} rsp_t;

	// Query travelling along the chain, one cell per cycle.
	typedef struct packed {
		logic        valid;
		logic        level_ok;
		logic [2:0]  level;
		logic [2:0]  element;
		logic [15:0] sample;
		logic        found;
		logic [5:0]  chosen;
	} tok_t;

	// Table write broadcast to every cell.
	typedef struct packed {
		logic        en;
		logic [2:0]  level;
		logic [5:0]  entry;
		logic [2:0]  bin;
		logic [15:0] cdf;
	} wr_t;

endpackage
`default_nettype wire

// File: hdl/bcis_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module bcis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// File: hdl/bcis_cell.sv
// One chain cell: holds one table entry for every power level and tests the passing query.
`default_nettype none
module bcis_cell import bcis_pkg::*; #(
	parameter int LEVELS = BCIS_LEVELS,
	parameter int IDX    = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire wr_t  wr,
	input  wire tok_t tok_in,
	output tok_t      tok_out
);

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam logic [5:0] MY_ID = 6'(IDX % 64);

	tok_t        tok_q;
	logic        we;
	logic [2:0]  lvl;
	logic [LW+2:0] lvl_ext;
	logic [LW-1:0] addr;
	logic [18:0] rdata;
	logic [2:0]  rd_bin;
	logic [15:0] rd_cdf;
	logic        match;

	assign we      = wr.en && (32'(wr.entry) == IDX);
	assign lvl     = we ? wr.level : tok_in.level;
	assign lvl_ext = {{LW{1'b0}}, lvl};
	assign addr    = lvl_ext[LW-1:0];

	bcis_ram #(
		.WIDTH (19),
		.DEPTH (LEVELS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata ({wr.bin, wr.cdf}),
		.rdata (rdata)
	);

	assign rd_bin = rdata[18:16];
	assign rd_cdf = rdata[15:0];

	// The read data lines up with the query registered in the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	assign match = tok_q.valid && tok_q.level_ok && !tok_q.found &&
		(rd_bin == tok_q.element) && (tok_q.sample < rd_cdf);

	always_comb begin
		tok_out = tok_q;
		if (match) begin
			tok_out.found  = 1'b1;
			tok_out.chosen = MY_ID;
		end
	end

endmodule
`default_nettype wire

// File: hdl/binned_cdf_index_sampler_unit.sv
// Top level of the binned CDF index sampler: request decode, cell chain and result registers.
//
//  channel | signals                     | word
//  --------+-----------------------------+--------------------------------------
//  request | req_valid, req_stall, req   | load one table entry or sample
//  result  | rsp_valid, rsp_stall, rsp   | found flag and chosen entry
//
// A load word is written into its cell and gives no result.
// A sample word walks the chain of ENTRIES cells, one cell per cycle, and its
// result reaches rsp_valid through the hold register and the output register.
// While a sample is in the chain or its result waits in the hold register,
// req_stall is high; it falls once the result moves into the output register.
// Reset clears only control state; table contents stay undefined until loaded.
`default_nettype none
module binned_cdf_index_sampler_unit import bcis_pkg::*; #(
	parameter int LEVELS  = BCIS_LEVELS,
	parameter int ENTRIES = BCIS_ENTRIES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic   accept;
	logic   level_ok;
	logic   busy_q;
	logic   res_valid_q;
	rsp_t   res_q;
	logic   out_valid_q;
	rsp_t   out_q;
	logic   load_out;
	wr_t    wr;
	tok_t   tok [ENTRIES+1];
	logic [ENTRIES-1:0] tok_vld;

	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;
	assign level_ok  = 32'(req.level) < LEVELS;

	always_comb begin
		wr.en    = accept && (req.func == FUNC_LOAD) && level_ok &&
			(32'(req.entry) < ENTRIES);
		wr.level = req.level;
		wr.entry = req.entry;
		wr.bin   = req.entry_bin;
		wr.cdf   = req.entry_cdf;
	end

	always_comb begin
		tok[0].valid    = accept && (req.func == FUNC_SAMPLE);
		tok[0].level_ok = level_ok;
		tok[0].level    = req.level;
		tok[0].element  = req.element;
		tok[0].sample   = (req.random_value == SAMPLE_TOP) ?
			(SAMPLE_TOP - 16'd1) : req.random_value;
		tok[0].found    = 1'b0;
		tok[0].chosen   = 6'd0;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		bcis_cell #(
			.LEVELS (LEVELS),
			.IDX    (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
		assign tok_vld[i] = tok[i+1].valid;
	end

	assign load_out = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok[0].valid) begin
				busy_q <= 1'b1;
			end else if (res_valid_q && load_out) begin
				busy_q <= 1'b0;
			end
			if (tok[ENTRIES].valid) begin
				res_valid_q <= 1'b1;
			end else if (load_out) begin
				res_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= res_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[ENTRIES].valid) begin
			res_q.found        <= tok[ENTRIES].found;
			res_q.chosen_entry <= tok[ENTRIES].chosen;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A result is held only while the request side is stalled.
	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> busy_q)
		else $error("result held while requests are open");

	// A sample reaches the hold register after walking every cell.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		tok[0].valid |-> ##(ENTRIES+1) res_valid_q)
		else $error("sample result did not arrive on time");

	// Only one query is ever in the chain.
	a_one_query: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one query in the chain");

	// An unset selection reports entry zero.
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |-> (rsp.chosen_entry == 6'd0))
		else $error("nonzero entry without a match");

endmodule
`default_nettype wire
